// ----- sv/nll_pkg.sv -----
package nll_pkg;

	// Character codes
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_SEVEN = 8'h37;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_XU    = 8'h58;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_BU    = 8'h42;
	localparam logic [7:0] CH_O     = 8'h6f;
	localparam logic [7:0] CH_OU    = 8'h4f;
	localparam logic [7:0] CH_POINT = 8'h2e;
	localparam logic [7:0] CH_P     = 8'h70;
	localparam logic [7:0] CH_PU    = 8'h50;
	localparam logic [7:0] CH_E     = 8'h65;
	localparam logic [7:0] CH_EU    = 8'h45;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_A_LO  = 8'h61;
	localparam logic [7:0] CH_F_LO  = 8'h66;
	localparam logic [7:0] CH_A_UP  = 8'h41;
	localparam logic [7:0] CH_F_UP  = 8'h46;
	localparam logic [7:0] HEX_LETTER_OFS = 8'd10;

	// Character classes
	localparam logic [3:0] CL_SIGN    = 4'd0;
	localparam logic [3:0] CL_PREFIX  = 4'd1;
	localparam logic [3:0] CL_INT     = 4'd2;
	localparam logic [3:0] CL_POINT   = 4'd3;
	localparam logic [3:0] CL_FRAC    = 4'd4;
	localparam logic [3:0] CL_EMARK   = 4'd5;
	localparam logic [3:0] CL_ESIGN   = 4'd6;
	localparam logic [3:0] CL_EDIG    = 4'd7;
	localparam logic [3:0] CL_SUFFIX  = 4'd8;
	localparam logic [3:0] CL_DISCARD = 4'd9;

	// Literal kinds
	localparam logic [2:0] KIND_BIN       = 3'd0;
	localparam logic [2:0] KIND_OCT       = 3'd1;
	localparam logic [2:0] KIND_DEC       = 3'd2;
	localparam logic [2:0] KIND_HEX       = 3'd3;
	localparam logic [2:0] KIND_DEC_FLOAT = 3'd4;
	localparam logic [2:0] KIND_HEX_FLOAT = 3'd5;
	localparam logic [2:0] KIND_ERROR     = 3'd6;

	// Result queue between front and back
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);
	localparam int Q_CW    = $clog2(Q_DEPTH + 1);
	localparam int MAX_RES = 3;

	typedef enum logic [3:0] {
		PH_START      = 4'd0,
		PH_AFTER_SIGN = 4'd1,
		PH_ZERO       = 4'd2,
		PH_ZERO_LET   = 4'd3,
		PH_INT        = 4'd4,
		PH_FRAC       = 4'd5,
		PH_EXP_SIGN   = 4'd6,
		PH_EXP_DIG    = 4'd7,
		PH_SUFFIX     = 4'd8,
		PH_DISCARD    = 4'd9
	} phase_t;

	typedef enum logic [1:0] {
		BASE_BIN = 2'd0,
		BASE_OCT = 2'd1,
		BASE_DEC = 2'd2,
		BASE_HEX = 2'd3
	} base_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       last_char;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic [3:0] char_class;
		logic [3:0] digit_value;
		logic       end_of_token;
		logic [2:0] literal_kind;
	} out_item_t;

	typedef struct packed {
		logic [1:0]                 count;
		out_item_t [MAX_RES-1:0]    res;
	} bundle_t;

endpackage

// ----- sv/numeric_literal_lexer.sv -----
// Numeric literal lexer: classifies the characters of one number token.
// Input channel (in_valid/in_ready/in_data): one request per character, with
// last_char set on the final character of the token. Output channel
// (out_valid/out_ready/out_data): one request per classified character.
// The front classifies a character in the cycle it is accepted and pushes its
// results into a four-entry queue; they leave the queue one per cycle while
// out_ready is high.
// A leading '0' and a following b/o/x letter produce no result until the
// character that resolves them arrives; that character then yields two or
// three results, drained one per cycle by the back end while out_ready is high.
// Throughput is one character per cycle while each character yields at most
// one result and out_ready stays high; the output port's one result per cycle
// sets the rate otherwise. The last result of a token carries end_of_token
// and literal_kind. When the receiver stalls, the queue absorbs up to four
// characters' results before in_ready drops. Reset empties the queue and
// returns the classifier to the start of a token.
module numeric_literal_lexer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  nll_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output nll_pkg::out_item_t out_data
);

	logic             push_valid;
	logic             push_ready;
	nll_pkg::bundle_t push_data;
	logic             head_valid;
	logic             pop;
	nll_pkg::bundle_t head_data;

	// Classify characters and track the token phase.
	nll_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	// Hold result groups so that front and back stall independently.
	nll_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.head_valid (head_valid),
		.pop        (pop),
		.head_data  (head_data)
	);

	// Drain each group one result per cycle while out_ready is high.
	nll_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_data  (head_data),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule

// ----- sv/nll_front.sv -----
module nll_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  nll_pkg::in_item_t  in_data,
	output logic               push_valid,
	input  logic               push_ready,
	output nll_pkg::bundle_t   push_data
);

	typedef struct packed {
		logic [3:0]      cls;
		logic [3:0]      dv;
		nll_pkg::phase_t ph;
		logic            frac;
		logic            expo;
		logic            err;
	} body_t;

	function automatic logic [4:0] dval(input logic [7:0] c);
		logic [7:0] t;
		begin
			if (c >= nll_pkg::CH_ZERO && c <= nll_pkg::CH_NINE) begin
				t = c - nll_pkg::CH_ZERO;
				return t[4:0];
			end else if (c >= nll_pkg::CH_A_LO && c <= nll_pkg::CH_F_LO) begin
				t = c - nll_pkg::CH_A_LO + nll_pkg::HEX_LETTER_OFS;
				return t[4:0];
			end else if (c >= nll_pkg::CH_A_UP && c <= nll_pkg::CH_F_UP) begin
				t = c - nll_pkg::CH_A_UP + nll_pkg::HEX_LETTER_OFS;
				return t[4:0];
			end
			return 5'd16;
		end
	endfunction

	// Classify one character of the token body.
	function automatic body_t body_fn(input nll_pkg::phase_t ph, input nll_pkg::base_t base,
			input logic [7:0] c);
		body_t r;
		body_t m;
		logic [4:0] v;
		logic below_rad;
		logic below_ten;
		begin
			v = dval(c);
			below_ten = (v < 5'd10);
			case (base)
				nll_pkg::BASE_BIN: below_rad = (v < 5'd2);
				nll_pkg::BASE_OCT: below_rad = (v < 5'd8);
				nll_pkg::BASE_DEC: below_rad = below_ten;
				default:           below_rad = (v < 5'd16);
			endcase
			// end of mantissa: exponent mark, suffix, or error for p outside hex
			m = '{cls: nll_pkg::CL_SUFFIX, dv: 4'd0, ph: nll_pkg::PH_SUFFIX,
				frac: 1'b0, expo: 1'b0, err: 1'b0};
			if (c == nll_pkg::CH_P || c == nll_pkg::CH_PU) begin
				if (base != nll_pkg::BASE_HEX) begin
					m.cls = nll_pkg::CL_DISCARD;
					m.ph  = nll_pkg::PH_DISCARD;
					m.err = 1'b1;
				end else begin
					m.cls = nll_pkg::CL_EMARK;
					m.ph  = nll_pkg::PH_EXP_SIGN;
				end
			end else if (c == nll_pkg::CH_E || c == nll_pkg::CH_EU) begin
				m.cls = nll_pkg::CL_EMARK;
				m.ph  = nll_pkg::PH_EXP_SIGN;
			end
			r = '{cls: nll_pkg::CL_DISCARD, dv: 4'd0, ph: ph,
				frac: 1'b0, expo: 1'b0, err: 1'b0};
			unique case (ph)
				nll_pkg::PH_INT: begin
					if (below_rad) begin
						r.cls = nll_pkg::CL_INT;
						r.dv  = v[3:0];
					end else if (base == nll_pkg::BASE_BIN || base == nll_pkg::BASE_OCT) begin
						r.cls = nll_pkg::CL_SUFFIX;
						r.ph  = nll_pkg::PH_SUFFIX;
					end else if (c == nll_pkg::CH_POINT) begin
						r.cls = nll_pkg::CL_POINT;
						r.ph  = nll_pkg::PH_FRAC;
					end else begin
						r = m;
					end
				end
				nll_pkg::PH_FRAC: begin
					if (below_rad) begin
						r.cls  = nll_pkg::CL_FRAC;
						r.dv   = v[3:0];
						r.frac = 1'b1;
					end else begin
						r = m;
					end
				end
				nll_pkg::PH_EXP_SIGN: begin
					if (c == nll_pkg::CH_PLUS || c == nll_pkg::CH_MINUS) begin
						r.cls = nll_pkg::CL_ESIGN;
						r.ph  = nll_pkg::PH_EXP_DIG;
					end else if (below_ten) begin
						r.cls  = nll_pkg::CL_EDIG;
						r.dv   = v[3:0];
						r.ph   = nll_pkg::PH_EXP_DIG;
						r.expo = 1'b1;
					end else begin
						r.cls = nll_pkg::CL_SUFFIX;
						r.ph  = nll_pkg::PH_SUFFIX;
					end
				end
				nll_pkg::PH_EXP_DIG: begin
					if (below_ten) begin
						r.cls  = nll_pkg::CL_EDIG;
						r.dv   = v[3:0];
						r.expo = 1'b1;
					end else begin
						r.cls = nll_pkg::CL_SUFFIX;
						r.ph  = nll_pkg::PH_SUFFIX;
					end
				end
				nll_pkg::PH_SUFFIX: r.cls = nll_pkg::CL_SUFFIX;
				default: r.cls = nll_pkg::CL_DISCARD;
			endcase
			return r;
		end
	endfunction

	nll_pkg::phase_t phase_q, phase_s;
	nll_pkg::base_t  base_q, base_s, body_base;
	nll_pkg::phase_t body_phase;
	logic            frac_q, frac_s;
	logic            exp_q, exp_s;
	logic            err_q, err_s;
	logic [1:0]      held_cnt_q, held_cnt_s;
	logic [7:0]      held0_q, held1_q;
	logic            held0_we, held1_we;
	logic [7:0]      c;
	logic            last;
	logic            acc;
	logic            is_sign, is_zero, is_point, is_nz_digit, is_oct_digit, is_prefix_let;
	logic [7:0]      c_off;
	body_t           bd;
	logic [1:0]      n_res;

	assign c    = in_data.ch;
	assign last = in_data.last_char;
	assign acc  = in_valid && push_ready;
	assign in_ready = push_ready;

	assign c_off         = c - nll_pkg::CH_ZERO;
	assign is_sign       = (c == nll_pkg::CH_PLUS) || (c == nll_pkg::CH_MINUS);
	assign is_zero       = (c == nll_pkg::CH_ZERO);
	assign is_point      = (c == nll_pkg::CH_POINT);
	assign is_nz_digit   = (c >= nll_pkg::CH_ONE) && (c <= nll_pkg::CH_NINE);
	assign is_oct_digit  = (c >= nll_pkg::CH_ZERO) && (c <= nll_pkg::CH_SEVEN);
	assign is_prefix_let = (c == nll_pkg::CH_B) || (c == nll_pkg::CH_BU) ||
		(c == nll_pkg::CH_O) || (c == nll_pkg::CH_OU) ||
		(c == nll_pkg::CH_X) || (c == nll_pkg::CH_XU);

	// Body phase and base seen by the classifier; held prefixes resolve into PH_INT.
	always_comb begin
		body_phase = phase_q;
		body_base  = base_q;
		if (phase_q == nll_pkg::PH_ZERO) begin
			body_phase = nll_pkg::PH_INT;
			body_base  = nll_pkg::BASE_DEC;
		end else if (phase_q == nll_pkg::PH_ZERO_LET) begin
			body_phase = nll_pkg::PH_INT;
			if (held1_q == nll_pkg::CH_B || held1_q == nll_pkg::CH_BU) begin
				body_base = nll_pkg::BASE_BIN;
			end else if (held1_q == nll_pkg::CH_O || held1_q == nll_pkg::CH_OU) begin
				body_base = nll_pkg::BASE_OCT;
			end else begin
				body_base = nll_pkg::BASE_HEX;
			end
		end
	end

	assign bd = body_fn(body_phase, body_base, c);

	// Next state (values after this character, before end-of-token clearing)
	always_comb begin
		phase_s    = phase_q;
		base_s     = base_q;
		frac_s     = frac_q;
		exp_s      = exp_q;
		err_s      = err_q;
		held_cnt_s = held_cnt_q;
		held0_we   = 1'b0;
		held1_we   = 1'b0;
		unique case (phase_q)
			nll_pkg::PH_START, nll_pkg::PH_AFTER_SIGN: begin
				if (phase_q == nll_pkg::PH_START && is_sign) begin
					phase_s = nll_pkg::PH_AFTER_SIGN;
					if (last) begin
						err_s = 1'b1;
					end
				end else begin
					base_s = nll_pkg::BASE_DEC;
					if (is_zero) begin
						if (last) begin
							phase_s = nll_pkg::PH_INT;
						end else begin
							held0_we   = 1'b1;
							held_cnt_s = 2'd1;
							phase_s    = nll_pkg::PH_ZERO;
						end
					end else if (is_point) begin
						phase_s = nll_pkg::PH_FRAC;
					end else if (is_nz_digit) begin
						phase_s = nll_pkg::PH_INT;
					end else begin
						err_s   = 1'b1;
						phase_s = nll_pkg::PH_DISCARD;
					end
				end
			end
			nll_pkg::PH_ZERO: begin
				if (is_oct_digit) begin
					base_s     = nll_pkg::BASE_OCT;
					phase_s    = nll_pkg::PH_INT;
					held_cnt_s = 2'd0;
				end else if (!last && is_prefix_let) begin
					held1_we   = 1'b1;
					held_cnt_s = 2'd2;
					phase_s    = nll_pkg::PH_ZERO_LET;
				end else begin
					base_s     = nll_pkg::BASE_DEC;
					held_cnt_s = 2'd0;
					phase_s    = bd.ph;
					frac_s     = frac_q | bd.frac;
					exp_s      = exp_q | bd.expo;
					err_s      = err_q | bd.err;
				end
			end
			default: begin
				base_s     = body_base;
				held_cnt_s = 2'd0;
				phase_s    = bd.ph;
				frac_s     = frac_q | bd.frac;
				exp_s      = exp_q | bd.expo;
				err_s      = err_q | bd.err;
			end
		endcase
	end

	// Outputs: results produced by this character
	always_comb begin
		logic [2:0] kind;
		push_data = '0;
		n_res     = 2'd0;
		unique case (phase_q)
			nll_pkg::PH_START, nll_pkg::PH_AFTER_SIGN: begin
				push_data.res[0].out_char = c;
				n_res = 2'd1;
				if (phase_q == nll_pkg::PH_START && is_sign) begin
					push_data.res[0].char_class = nll_pkg::CL_SIGN;
				end else if (is_zero) begin
					push_data.res[0].char_class = nll_pkg::CL_INT;
					if (!last) begin
						n_res = 2'd0;
					end
				end else if (is_point) begin
					push_data.res[0].char_class = nll_pkg::CL_POINT;
				end else if (is_nz_digit) begin
					push_data.res[0].char_class  = nll_pkg::CL_INT;
					push_data.res[0].digit_value = c_off[3:0];
				end else begin
					push_data.res[0].char_class = nll_pkg::CL_DISCARD;
				end
			end
			nll_pkg::PH_ZERO: begin
				push_data.res[0].out_char = held0_q;
				push_data.res[1].out_char = c;
				n_res = 2'd2;
				if (is_oct_digit) begin
					push_data.res[0].char_class  = nll_pkg::CL_PREFIX;
					push_data.res[1].char_class  = nll_pkg::CL_INT;
					push_data.res[1].digit_value = c_off[3:0];
				end else if (!last && is_prefix_let) begin
					n_res = 2'd0;
				end else begin
					push_data.res[0].char_class  = nll_pkg::CL_INT;
					push_data.res[1].char_class  = bd.cls;
					push_data.res[1].digit_value = bd.dv;
				end
			end
			nll_pkg::PH_ZERO_LET: begin
				push_data.res[0].out_char    = held0_q;
				push_data.res[0].char_class  = nll_pkg::CL_PREFIX;
				push_data.res[1].out_char    = held1_q;
				push_data.res[1].char_class  = nll_pkg::CL_PREFIX;
				push_data.res[2].out_char    = c;
				push_data.res[2].char_class  = bd.cls;
				push_data.res[2].digit_value = bd.dv;
				n_res = 2'd3;
			end
			default: begin
				push_data.res[0].out_char    = c;
				push_data.res[0].char_class  = bd.cls;
				push_data.res[0].digit_value = bd.dv;
				n_res = 2'd1;
			end
		endcase

		if (err_s) begin
			kind = nll_pkg::KIND_ERROR;
		end else if (base_s == nll_pkg::BASE_DEC) begin
			kind = (frac_s || exp_s) ? nll_pkg::KIND_DEC_FLOAT : nll_pkg::KIND_DEC;
		end else if (base_s == nll_pkg::BASE_HEX) begin
			kind = (frac_s || exp_s) ? nll_pkg::KIND_HEX_FLOAT : nll_pkg::KIND_HEX;
		end else if (base_s == nll_pkg::BASE_OCT) begin
			kind = nll_pkg::KIND_OCT;
		end else begin
			kind = nll_pkg::KIND_BIN;
		end

		// mark the last result of the final character
		if (last) begin
			case (n_res)
				2'd1: begin
					push_data.res[0].end_of_token = 1'b1;
					push_data.res[0].literal_kind = kind;
				end
				2'd2: begin
					push_data.res[1].end_of_token = 1'b1;
					push_data.res[1].literal_kind = kind;
				end
				2'd3: begin
					push_data.res[2].end_of_token = 1'b1;
					push_data.res[2].literal_kind = kind;
				end
				default: ;
			endcase
		end
		push_data.count = n_res;
	end

	assign push_valid = in_valid && (n_res != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= nll_pkg::PH_START;
			base_q     <= nll_pkg::BASE_DEC;
			frac_q     <= 1'b0;
			exp_q      <= 1'b0;
			err_q      <= 1'b0;
			held_cnt_q <= 2'd0;
		end else if (acc) begin
			if (last) begin
				phase_q    <= nll_pkg::PH_START;
				base_q     <= nll_pkg::BASE_DEC;
				frac_q     <= 1'b0;
				exp_q      <= 1'b0;
				err_q      <= 1'b0;
				held_cnt_q <= 2'd0;
			end else begin
				phase_q    <= phase_s;
				base_q     <= base_s;
				frac_q     <= frac_s;
				exp_q      <= exp_s;
				err_q      <= err_s;
				held_cnt_q <= held_cnt_s;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && held0_we) begin
			held0_q <= c;
		end
		if (acc && held1_we) begin
			held1_q <= c;
		end
	end

	a_held_one: assert property (@(posedge clk) disable iff (!arst_n)
		(held_cnt_q == 2'd1) == (phase_q == nll_pkg::PH_ZERO))
		else $error("held count out of step with zero phase");

	a_held_two: assert property (@(posedge clk) disable iff (!arst_n)
		(held_cnt_q == 2'd2) == (phase_q == nll_pkg::PH_ZERO_LET))
		else $error("held count out of step with prefix letter phase");

	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && last) |=> (phase_q == nll_pkg::PH_START && held_cnt_q == 2'd0))
		else $error("token end did not return to start");

endmodule

// ----- sv/nll_queue.sv -----
module nll_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  nll_pkg::bundle_t  push_data,
	output logic              head_valid,
	input  logic              pop,
	output nll_pkg::bundle_t  head_data
);

	nll_pkg::bundle_t              slots_q [nll_pkg::Q_DEPTH];
	logic [nll_pkg::Q_AW-1:0]      wr_ptr_q, rd_ptr_q;
	logic [nll_pkg::Q_CW-1:0]      cnt_q;
	logic                          do_push, do_pop;

	assign push_ready = (cnt_q != nll_pkg::Q_CW'(nll_pkg::Q_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_data  = slots_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= nll_pkg::Q_CW'(nll_pkg::Q_DEPTH))
		else $error("queue fill beyond depth");

endmodule

// ----- sv/nll_back.sv -----
module nll_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  nll_pkg::bundle_t   head_data,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output nll_pkg::out_item_t out_data
);

	logic [1:0] idx_q;
	logic       last_of_bundle;

	assign out_valid      = head_valid;
	assign last_of_bundle = (idx_q == head_data.count - 2'd1);
	assign pop            = out_valid && out_ready && last_of_bundle;

	always_comb begin
		case (idx_q)
			2'd0:    out_data = head_data.res[0];
			2'd1:    out_data = head_data.res[1];
			default: out_data = head_data.res[2];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
		end else if (out_valid && out_ready) begin
			idx_q <= last_of_bundle ? 2'd0 : idx_q + 2'd1;
		end
	end

	a_idx_in_bundle: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> (idx_q < head_data.count))
		else $error("result index past bundle count");

	a_bundle_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> (head_data.count != 2'd0))
		else $error("empty bundle in queue");

endmodule
